@@ rtl/pcssq_pkg.sv @@
// ----------------------------------------------------------------------------
// pcssq_pkg
// Shared types and codes for the per-channel scale and shift quantize unit.
// ----------------------------------------------------------------------------
package pcssq_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYOUT      = 3'd0,
    CFG_CHANNELS    = 3'd1,
    CFG_SPATIAL     = 3'd2,
    CFG_INPUT_FIXED = 3'd3,
    CFG_QUANT_OUT   = 3'd4,
    CFG_CLAMP_LOWER = 3'd5,
    CFG_CLAMP_UPPER = 3'd6
  } cfg_reg_t;

  // Input word commands.
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  // One coefficient table entry: Q8.24 scale and Q16.16 shift.
  typedef struct packed {
    logic [31:0] scale;
    logic [31:0] shift;
  } coef_t;

endpackage

@@ rtl/pcssq_coef_mem.sv @@
// ----------------------------------------------------------------------------
// pcssq_coef_mem
// Per-channel coefficient store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcssq_coef_mem #(
  parameter int CHANNEL_SLOTS = 1024,
  parameter int AW            = 10
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  pcssq_pkg::coef_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output pcssq_pkg::coef_t rd_data
);
  import pcssq_pkg::*;

  coef_t mem [CHANNEL_SLOTS];
  coef_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/per_channel_scale_shift_quantize_unit.sv @@
// ----------------------------------------------------------------------------
// per_channel_scale_shift_quantize_unit
// Streams tensor samples through value * scale + shift with per-channel
// coefficients, then rounds and clamps to a byte or saturates to Q16.16.
// ----------------------------------------------------------------------------
// Usage. Words enter on the in_ channel (valid/stall). A word with cmd low
// loads the scale and shift of one channel slot and produces no result; a
// word with cmd high is one sample and produces exactly one result word on
// the out_ channel, in order. Geometry and mode registers are written on the
// cfg_ port while the unit is idle; a write to layout, channel count or
// spatial size returns the position counters to the first sample of an image.
// A sample's result word reaches out_valid through stages 1 to 4 and the
// output register. Throughput: one word per cycle, loads and samples alike,
// while in_stall is low. The coefficient memory takes a load's write and
// a sample's read on separate ports; the 32 x 32 multiply has its own stage.
// Reset clears the configuration to its defaults, the position counters and
// all valid flags. The coefficient memory is not cleared; a channel must be
// loaded before its first sample. When the receiver stalls, each pipeline
// stage holds only if the stage after it is full, so bubbles close up and
// in_stall rises once every stage up to the memory read is occupied.
// ----------------------------------------------------------------------------
module per_channel_scale_shift_quantize_unit #(
  parameter int CHANNEL_SLOTS = 1024,
  parameter int SPATIAL_MAX   = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration port.
  input  logic                               cfg_wr_en,
  input  logic [pcssq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcssq_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel.
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [9:0]                         in_slot,
  input  logic signed [31:0]                 in_scale_word,
  input  logic signed [31:0]                 in_shift_word,
  input  logic signed [31:0]                 in_sample,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [31:0]                 out_result_value,
  output logic [9:0]                         out_channel_of_result,
  output logic                               out_last_of_image
);
  import pcssq_pkg::*;

  localparam int AW = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

  // Configuration registers.
  logic        layout_r;
  logic [10:0] channels_r;
  logic [16:0] spatial_r;
  logic        input_fixed_r;
  logic        quant_out_r;
  logic [7:0]  clamp_lower_r;
  logic [7:0]  clamp_upper_r;
  logic        geom_write;

  // Position counters.
  logic [9:0]  ch_pos_r, ch_pos_nxt;
  logic [15:0] sp_pos_r, sp_pos_nxt;

  always_comb begin
    geom_write = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LAYOUT, CFG_CHANNELS, CFG_SPATIAL: geom_write = 1'b1;
        default:                               geom_write = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r      <= 1'b0;
      channels_r    <= 11'd1;
      spatial_r     <= 17'd1;
      input_fixed_r <= 1'b0;
      quant_out_r   <= 1'b1;
      clamp_lower_r <= 8'd0;
      clamp_upper_r <= 8'd255;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LAYOUT:      layout_r      <= cfg_data[0];
        CFG_CHANNELS:    channels_r    <= cfg_data[10:0];
        CFG_SPATIAL:     spatial_r     <= cfg_data[16:0];
        CFG_INPUT_FIXED: input_fixed_r <= cfg_data[0];
        CFG_QUANT_OUT:   quant_out_r   <= cfg_data[0];
        CFG_CLAMP_LOWER: clamp_lower_r <= cfg_data[7:0];
        CFG_CLAMP_UPPER: clamp_upper_r <= cfg_data[7:0];
        default:         ;
      endcase
    end
  end

  // Pipeline control. Each stage moves on when the stage after it is empty
  // or is itself moving on.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en_out;
  logic in_take, take_sample, take_load;

  assign en_out = !out_valid_r || !out_stall;
  assign en4    = !v4_r || en_out;
  assign en3    = !v3_r || en4;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;

  assign in_stall    = !en1;
  assign in_take     = in_valid && en1;
  assign take_sample = in_take && (in_cmd == CMD_PROCESS);
  assign take_load   = in_take && (in_cmd == CMD_LOAD) && (32'(in_slot) < CHANNEL_SLOTS);

  // Effective geometry and the channel and pixel of the current sample.
  logic [10:0] chan_eff, chan_sat;
  logic [16:0] spat_eff, spat_sat;
  logic [9:0]  ch_cur;
  logic [15:0] sp_cur;
  logic [10:0] ch_inc;
  logic [16:0] sp_inc;
  logic        ch_wrap, sp_wrap, last_cur;

  always_comb begin
    chan_sat = (channels_r == 11'd0) ? 11'd1 : channels_r;
    chan_eff = (chan_sat > CHANNEL_SLOTS) ? 11'(CHANNEL_SLOTS) : chan_sat;
    spat_sat = (spatial_r == 17'd0) ? 17'd1 : spatial_r;
    spat_eff = (spat_sat > SPATIAL_MAX) ? 17'(SPATIAL_MAX) : spat_sat;

    // A counter left beyond the geometry restarts at zero.
    ch_cur = ({1'b0, ch_pos_r} >= chan_eff) ? 10'd0 : ch_pos_r;
    sp_cur = ({1'b0, sp_pos_r} >= spat_eff) ? 16'd0 : sp_pos_r;

    last_cur = ({1'b0, ch_cur} == chan_eff - 11'd1) &&
               ({1'b0, sp_cur} == spat_eff - 17'd1);

    ch_inc  = {1'b0, ch_cur} + 11'd1;
    sp_inc  = {1'b0, sp_cur} + 17'd1;
    ch_wrap = (ch_inc >= chan_eff);
    sp_wrap = (sp_inc >= spat_eff);

    if (layout_r == 1'b0) begin
      // Channel-major planes: pixels run fastest.
      if (sp_wrap) begin
        sp_pos_nxt = 16'd0;
        ch_pos_nxt = ch_wrap ? 10'd0 : ch_inc[9:0];
      end else begin
        sp_pos_nxt = sp_inc[15:0];
        ch_pos_nxt = ch_cur;
      end
    end else begin
      // Interleaved: channels run fastest.
      if (ch_wrap) begin
        ch_pos_nxt = 10'd0;
        sp_pos_nxt = sp_wrap ? 16'd0 : sp_inc[15:0];
      end else begin
        ch_pos_nxt = ch_inc[9:0];
        sp_pos_nxt = sp_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_pos_r <= 10'd0;
      sp_pos_r <= 16'd0;
    end else if (geom_write) begin
      ch_pos_r <= 10'd0;
      sp_pos_r <= 16'd0;
    end else if (take_sample) begin
      ch_pos_r <= ch_pos_nxt;
      sp_pos_r <= sp_pos_nxt;
    end
  end

  // Coefficient memory. Loads write and samples read in the same stage, so
  // a sample always sees every load accepted before it.
  coef_t coef_wr, coef_rd;

  assign coef_wr.scale = in_scale_word;
  assign coef_wr.shift = in_shift_word;

  pcssq_coef_mem #(
    .CHANNEL_SLOTS (CHANNEL_SLOTS),
    .AW            (AW)
  ) u_coef_mem (
    .clk     (clk),
    .wr_en   (take_load),
    .wr_addr (AW'(32'(in_slot))),
    .wr_data (coef_wr),
    .rd_en   (en1),
    .rd_addr (AW'(32'(ch_cur))),
    .rd_data (coef_rd)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= take_sample;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en_out) out_valid_r <= v4_r;
    end
  end

  // Stage 1: sample in Q16.16 alongside the memory read.
  logic signed [31:0] x1_r, x1_nxt;
  logic [9:0]         ch1_r, ch2_r, ch3_r, ch4_r;
  logic               last1_r, last2_r, last3_r, last4_r;

  assign x1_nxt = input_fixed_r ? in_sample : $signed({8'd0, in_sample[7:0], 16'd0});

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r    <= x1_nxt;
      ch1_r   <= ch_cur;
      last1_r <= last_cur;
    end
  end

  // Stage 2: exact product in Q.40.
  logic signed [63:0] prod2_r, prod2_nxt;
  logic [31:0]        shift2_r;

  assign prod2_nxt = x1_r * $signed(coef_rd.scale);

  always_ff @(posedge clk) begin
    if (en2) begin
      prod2_r  <= prod2_nxt;
      shift2_r <= coef_rd.shift;
      ch2_r    <= ch1_r;
      last2_r  <= last1_r;
    end
  end

  // Stage 3: shift aligned to Q.40 and added.
  logic signed [63:0] acc3_r, acc3_nxt;

  assign acc3_nxt = prod2_r + $signed({{8{shift2_r[31]}}, shift2_r, 24'd0});

  always_ff @(posedge clk) begin
    if (en3) begin
      acc3_r  <= acc3_nxt;
      ch3_r   <= ch2_r;
      last3_r <= last2_r;
    end
  end

  // Stage 4: half away from zero. Adding half, less one when negative, and
  // then an arithmetic shift gives the rounded value for either sign.
  logic signed [63:0] rnd4_r, rnd4_nxt;
  logic [63:0]        half;

  assign half     = quant_out_r ? 64'h0000_0080_0000_0000 : 64'h0000_0000_0080_0000;
  assign rnd4_nxt = acc3_r + $signed(half) - $signed(64'(acc3_r[63]));

  always_ff @(posedge clk) begin
    if (en4) begin
      rnd4_r  <= rnd4_nxt;
      ch4_r   <= ch3_r;
      last4_r <= last3_r;
    end
  end

  // Output stage: clamp or saturate into the result register.
  logic signed [23:0] q_int;
  logic signed [23:0] q_low, q_up, q_clamped;
  logic [39:0]        q_fix;
  logic [31:0]        result_nxt;
  logic signed [31:0] result_r;
  logic [9:0]         ch_out_r;
  logic               last_out_r;

  always_comb begin
    q_int = rnd4_r[63:40];
    q_low = $signed({16'd0, clamp_lower_r});
    q_up  = $signed({16'd0, clamp_upper_r});
    // Lower bound first, then upper, so crossed bounds give the upper one.
    q_clamped = (q_int < q_low) ? q_low : q_int;
    if (q_clamped > q_up) begin
      q_clamped = q_up;
    end

    q_fix = rnd4_r[63:24];
    if (quant_out_r) begin
      result_nxt = {24'd0, q_clamped[7:0]};
    end else if (!q_fix[39] && (|q_fix[38:31])) begin
      result_nxt = 32'h7FFF_FFFF;
    end else if (q_fix[39] && !(&q_fix[38:31])) begin
      result_nxt = 32'h8000_0000;
    end else begin
      result_nxt = q_fix[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      result_r   <= $signed(result_nxt);
      ch_out_r   <= ch4_r;
      last_out_r <= last4_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_value      = result_r;
  assign out_channel_of_result = ch_out_r;
  assign out_last_of_image     = last_out_r;

endmodule
